// ===== rtl/signed_int_to_decimal_ascii_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SITD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sitd assertion failed");

// Next-cycle implication, disabled during reset.
`define SITD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitd assertion failed");

`endif

// ===== rtl/sitd_pkg.sv =====
// ----------------------------------------------------------------------------
// sitd_pkg
// Shared types and character codes for the signed integer to ASCII converter.
// ----------------------------------------------------------------------------
package sitd_pkg;

    localparam int CHAR_W = 6;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } sitd_state_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift_digit;
        logic emit_sign;
        logic emit_digit;
    } sitd_cmd_t;

    typedef struct packed {
        logic top_zero;
        logic neg;
        logic bits_done;
        logic dig_last;
    } sitd_status_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Prints a signed two's complement integer as decimal ASCII text, one
// character per strobe, minus sign first, no leading zeros.
//
//   channel   signals                      handshake
//   -------   --------------------------   -------------------------------
//   input     value                        start && !busy at a rising edge
//   result    ascii_char, last             strobe, one cycle, no back-off
//
// One word takes DATA_WIDTH shift-and-add-3 steps, then each BCD digit
// position is skipped or printed; a negative value gets its minus sign
// before the first printed digit. busy falls in the cycle the last
// character is on the ports. Reset clears the sequencer and the strobe;
// nothing else needs clearing. The receiver cannot stall, so only start
// holds the sequencer in idle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
    import sitd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] value,
    output logic [CHAR_W-1:0]     ascii_char,
    output logic                  last,
    output logic                  strobe
);

    // decimal digits of 2^(DATA_WIDTH-1)
    localparam int NUM_DIGITS = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;

    sitd_cmd_t    cmd;
    sitd_status_t status;

    sitd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sitd_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .ascii_char (ascii_char),
        .last       (last),
        .strobe     (strobe)
    );

endmodule

// ===== rtl/sitd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitd_ctrl
// Sequencer: load, binary to BCD conversion, leading zero skip, sign, digits.
// ----------------------------------------------------------------------------
module sitd_ctrl
    import sitd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  sitd_status_t status,
    output sitd_cmd_t    cmd,
    output logic         busy
);

    sitd_state_t state_reg;
    sitd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (status.bits_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // keep at least one digit so zero prints as "0"
                if (!status.top_zero || status.dig_last)
                begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.dig_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_CONVERT:
            begin
                cmd.dabble = 1'b1;
            end
            ST_SKIP:
            begin
                cmd.shift_digit = status.top_zero && !status.dig_last;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/sitd_datapath.sv =====
// ----------------------------------------------------------------------------
// sitd_datapath
// Magnitude register, shift-and-add-3 BCD converter, digit counter and the
// registered character output.
// ----------------------------------------------------------------------------
module sitd_datapath
    import sitd_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int NUM_DIGITS = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [DATA_WIDTH-1:0]  value,
    input  sitd_cmd_t              cmd,
    output sitd_status_t           status,
    output logic [CHAR_W-1:0]      ascii_char,
    output logic                   last,
    output logic                   strobe
);

    localparam int BCD_W  = 4 * NUM_DIGITS;
    localparam int BIT_CW = $clog2(DATA_WIDTH + 1);
    localparam int DIG_CW = $clog2(NUM_DIGITS + 1);

    logic [DATA_WIDTH-1:0] mag_reg,     mag_next;
    logic [BCD_W-1:0]      bcd_reg,     bcd_next;
    logic                  neg_reg,     neg_next;
    logic [BIT_CW-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0]     dig_cnt_reg, dig_cnt_next;
    logic [CHAR_W-1:0]     char_reg,    char_next;
    logic                  last_reg,    last_next;
    logic                  strobe_reg,  strobe_next;

    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        strobe_next  = 1'b0;

        if (cmd.load)
        begin
            // unsigned negate: the most negative value maps to 2^(DATA_WIDTH-1)
            mag_next     = value[DATA_WIDTH-1] ? (~value + DATA_WIDTH'(1)) : value;
            bcd_next     = '0;
            neg_next     = value[DATA_WIDTH-1];
            bit_cnt_next = BIT_CW'(DATA_WIDTH);
            dig_cnt_next = DIG_CW'(NUM_DIGITS);
        end

        if (cmd.dabble)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[DATA_WIDTH-1]};
            mag_next     = {mag_reg[DATA_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - BIT_CW'(1);
        end

        if (cmd.shift_digit || cmd.emit_digit)
        begin
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
            dig_cnt_next = dig_cnt_reg - DIG_CW'(1);
        end

        if (cmd.emit_sign)
        begin
            char_next   = CHAR_MINUS;
            last_next   = 1'b0;
            strobe_next = 1'b1;
        end

        if (cmd.emit_digit)
        begin
            char_next   = CHAR_ZERO | {2'b00, top_digit};
            last_next   = (dig_cnt_reg == DIG_CW'(1));
            strobe_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign status.top_zero  = (top_digit == 4'd0);
    assign status.neg       = neg_reg;
    assign status.bits_done = (bit_cnt_reg == BIT_CW'(1));
    assign status.dig_last  = (dig_cnt_reg == DIG_CW'(1));

    assign ascii_char = char_reg;
    assign last       = last_reg;
    assign strobe     = strobe_reg;

endmodule

// ===== rtl/sitd_checker.sv =====
// ----------------------------------------------------------------------------
// sitd_checker
// Port-level checks on the handshake and the character stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module sitd_checker
    import sitd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [CHAR_W-1:0] ascii_char,
    input logic              last,
    input logic              strobe
);

    logic is_minus;
    logic is_digit;

    assign is_minus = (ascii_char == CHAR_MINUS);
    assign is_digit = (ascii_char >= CHAR_ZERO) && (ascii_char <= (CHAR_ZERO + 6'd9));

    `SITD_ASSERT_NOW(a_char_legal, clk, rst_n, strobe, is_minus || is_digit)
    `SITD_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
    `SITD_ASSERT_NEXT(a_gap_after_last, clk, rst_n, strobe && last, !strobe)
    `SITD_ASSERT_NEXT(a_digit_after_minus, clk, rst_n, strobe && is_minus, strobe && is_digit)

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .ascii_char (ascii_char),
    .last       (last),
    .strobe     (strobe)
);
